// ===== rtl/core/agt_pkg.sv =====
// shared types and constants of the affine georeference transform
package agt_pkg;

	localparam int FRAC_SHIFT = 24;
	localparam int APB_DW = 64;
	localparam int APB_AW = 6;
	localparam logic [63:0] ONE_Q24 = 64'd16777216;

	typedef enum logic [2:0] {
		REG_M11,
		REG_M12,
		REG_M21,
		REG_M22,
		REG_COL_OFF,
		REG_ROW_OFF
	} agt_reg_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_UNDEF    = 2'd1,
		ST_SINGULAR = 2'd2,
		ST_SAT      = 2'd3
	} agt_status_t;

	typedef struct packed {
		logic vld;
		logic inv;
		logic undef;
		logic sing;
		logic fsat;
		logic ovf0;
		logic neg0;
		logic ovf1;
		logic neg1;
	} agt_ctl_t;

endpackage

// ===== rtl/core/affine_georef_transform.sv =====
// top level of the fixed-point affine georeference transform
//
// slave stream s_*: one request per transaction; s_tdata holds first_in and
// second_in, s_tuser holds req_type and in_undefined. master stream m_*: one
// result per transaction; m_tdata holds first_out and second_out, m_tuser
// holds status. matrix and offsets are written over the apb port; the user must
// write them only while no request is in flight; the block does not check it.
// a request passes six front stages (offset subtract, split products,
// product assembly, sums, rounding, clamp and divider set-up), a row of
// COORD_WIDTH+1 divider cells that each settle one quotient bit of both
// outputs, a rounding stage and the output register; results leave in request
// order. throughput is one request per cycle when not stalled; forward
// requests ride the same row so order is kept.
// reset clears all valid flags and loads the identity-like matrix with
// negated row axis and zero offsets.
// when the receiver stalls, one more result is caught in the skid register,
// then s_tready drops and the whole pipeline holds until m_tready returns.
module affine_georef_transform #(
	parameter int COORD_WIDTH = 48,
	parameter int COEFF_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [agt_pkg::APB_AW-1:0]            paddr,
	input  logic [agt_pkg::APB_DW-1:0]            pwdata,
	output logic [agt_pkg::APB_DW-1:0]            prdata,
	output logic                                  pready,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// first_in, second_in, zero pad
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]    s_tdata,
	// req_type, in_undefined
	input  logic [1:0]                            s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// first_out, second_out, zero pad
	output logic [((2*COORD_WIDTH+7)/8)*8-1:0]    m_tdata,
	// status
	output logic [1:0]                            m_tuser
);

	localparam int W  = COORD_WIDTH;
	localparam int C  = COEFF_WIDTH;
	localparam int QB = W + 1;
	localparam int RW = 2 * C;

	logic signed [C-1:0] m11, m12, m21, m22;
	logic signed [W-1:0] col_off, row_off;
	logic                en;

	agt_pkg::agt_ctl_t ctl [QB+1];
	logic [RW-1:0]     dd  [QB+1];
	logic [RW-1:0]     r0  [QB+1];
	logic [QB-1:0]     q0  [QB+1];
	logic [RW-1:0]     r1  [QB+1];
	logic [QB-1:0]     q1  [QB+1];
	logic [W-1:0]      f0  [QB+1];
	logic [W-1:0]      f1  [QB+1];

	assign s_tready = en;

	agt_cfg #(
		.COORD_WIDTH(COORD_WIDTH),
		.COEFF_WIDTH(COEFF_WIDTH)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.m11     (m11),
		.m12     (m12),
		.m21     (m21),
		.m22     (m22),
		.col_off (col_off),
		.row_off (row_off)
	);

	agt_front #(
		.COORD_WIDTH(COORD_WIDTH),
		.COEFF_WIDTH(COEFF_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (s_tvalid),
		.in_inv    (s_tuser[0]),
		.in_undef  (s_tuser[1]),
		.in_first  (s_tdata[W-1:0]),
		.in_second (s_tdata[2*W-1:W]),
		.m11       (m11),
		.m12       (m12),
		.m21       (m21),
		.m22       (m22),
		.col_off   (col_off),
		.row_off   (row_off),
		.ctl_o     (ctl[0]),
		.d_o       (dd[0]),
		.r0_o      (r0[0]),
		.q0_o      (q0[0]),
		.r1_o      (r1[0]),
		.q1_o      (q1[0]),
		.f0_o      (f0[0]),
		.f1_o      (f1[0])
	);

	generate
		for (genvar i = 0; i < QB; i++) begin : g_cell
			agt_div_cell #(
				.COORD_WIDTH(COORD_WIDTH),
				.COEFF_WIDTH(COEFF_WIDTH)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en),
				.ctl_i  (ctl[i]),
				.d_i    (dd[i]),
				.r0_i   (r0[i]),
				.q0_i   (q0[i]),
				.r1_i   (r1[i]),
				.q1_i   (q1[i]),
				.f0_i   (f0[i]),
				.f1_i   (f1[i]),
				.ctl_o  (ctl[i+1]),
				.d_o    (dd[i+1]),
				.r0_o   (r0[i+1]),
				.q0_o   (q0[i+1]),
				.r1_o   (r1[i+1]),
				.q1_o   (q1[i+1]),
				.f0_o   (f0[i+1]),
				.f1_o   (f1[i+1])
			);
		end
	endgenerate

	agt_back #(
		.COORD_WIDTH(COORD_WIDTH),
		.COEFF_WIDTH(COEFF_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_i    (ctl[QB]),
		.d_i      (dd[QB]),
		.r0_i     (r0[QB]),
		.q0_i     (q0[QB]),
		.r1_i     (r1[QB]),
		.q1_i     (q1[QB]),
		.f0_i     (f0[QB]),
		.f1_i     (f1[QB]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== rtl/core/agt_cfg.sv =====
// configuration register file with apb write and read access
module agt_cfg #(
	parameter int COORD_WIDTH = 48,
	parameter int COEFF_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [agt_pkg::APB_AW-1:0]       paddr,
	input  logic [agt_pkg::APB_DW-1:0]       pwdata,
	output logic [agt_pkg::APB_DW-1:0]       prdata,
	output logic                             pready,
	output logic signed [COEFF_WIDTH-1:0]    m11,
	output logic signed [COEFF_WIDTH-1:0]    m12,
	output logic signed [COEFF_WIDTH-1:0]    m21,
	output logic signed [COEFF_WIDTH-1:0]    m22,
	output logic signed [COORD_WIDTH-1:0]    col_off,
	output logic signed [COORD_WIDTH-1:0]    row_off
);

	localparam int C = COEFF_WIDTH;
	localparam int W = COORD_WIDTH;
	localparam logic signed [C-1:0] M_ONE = C'(agt_pkg::ONE_Q24);
	localparam logic signed [C-1:0] M_NEG_ONE = C'(64'd0 - agt_pkg::ONE_Q24);

	logic signed [C-1:0] m11_q, m12_q, m21_q, m22_q;
	logic signed [W-1:0] col_off_q, row_off_q;
	agt_pkg::agt_reg_t   idx;
	logic                wr;

	assign idx    = agt_pkg::agt_reg_t'(paddr[agt_pkg::APB_AW-1:3]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m11_q     <= M_ONE;
			m12_q     <= '0;
			m21_q     <= '0;
			m22_q     <= M_NEG_ONE;
			col_off_q <= '0;
			row_off_q <= '0;
		end else if (wr) begin
			case (idx)
				agt_pkg::REG_M11:     m11_q <= pwdata[C-1:0];
				agt_pkg::REG_M12:     m12_q <= pwdata[C-1:0];
				agt_pkg::REG_M21:     m21_q <= pwdata[C-1:0];
				agt_pkg::REG_M22:     m22_q <= pwdata[C-1:0];
				agt_pkg::REG_COL_OFF: col_off_q <= pwdata[W-1:0];
				agt_pkg::REG_ROW_OFF: row_off_q <= pwdata[W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			agt_pkg::REG_M11:     prdata = agt_pkg::APB_DW'(m11_q);
			agt_pkg::REG_M12:     prdata = agt_pkg::APB_DW'(m12_q);
			agt_pkg::REG_M21:     prdata = agt_pkg::APB_DW'(m21_q);
			agt_pkg::REG_M22:     prdata = agt_pkg::APB_DW'(m22_q);
			agt_pkg::REG_COL_OFF: prdata = agt_pkg::APB_DW'(col_off_q);
			agt_pkg::REG_ROW_OFF: prdata = agt_pkg::APB_DW'(row_off_q);
			default:              prdata = '0;
		endcase
	end

	assign m11     = m11_q;
	assign m12     = m12_q;
	assign m21     = m21_q;
	assign m22     = m22_q;
	assign col_off = col_off_q;
	assign row_off = row_off_q;

endmodule

// ===== rtl/core/agt_front.sv =====
// front pipeline: offsets, split products, sums, rounding and divider set-up
module agt_front #(
	parameter int COORD_WIDTH = 48,
	parameter int COEFF_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_vld,
	input  logic                                in_inv,
	input  logic                                in_undef,
	input  logic signed [COORD_WIDTH-1:0]       in_first,
	input  logic signed [COORD_WIDTH-1:0]       in_second,
	input  logic signed [COEFF_WIDTH-1:0]       m11,
	input  logic signed [COEFF_WIDTH-1:0]       m12,
	input  logic signed [COEFF_WIDTH-1:0]       m21,
	input  logic signed [COEFF_WIDTH-1:0]       m22,
	input  logic signed [COORD_WIDTH-1:0]       col_off,
	input  logic signed [COORD_WIDTH-1:0]       row_off,
	output agt_pkg::agt_ctl_t                   ctl_o,
	output logic [2*COEFF_WIDTH-1:0]            d_o,
	output logic [2*COEFF_WIDTH-1:0]            r0_o,
	output logic [COORD_WIDTH:0]                q0_o,
	output logic [2*COEFF_WIDTH-1:0]            r1_o,
	output logic [COORD_WIDTH:0]                q1_o,
	output logic [COORD_WIDTH-1:0]              f0_o,
	output logic [COORD_WIDTH-1:0]              f1_o
);

	localparam int W    = COORD_WIDTH;
	localparam int C    = COEFF_WIDTH;
	localparam int FRAC = agt_pkg::FRAC_SHIFT;
	localparam int U    = W + 1;
	localparam int LO   = (U + 1) / 2;
	localparam int HI   = U - LO;
	localparam int PW   = C + U;
	localparam int SW   = PW + 1;
	localparam int RW   = 2 * C;
	localparam int DW   = 2 * C + 1;
	localparam int QB   = W + 1;
	localparam int SH   = QB - FRAC;
	localparam int XW   = RW + SW;
	localparam logic signed [SW-1:0] RND = SW'(64'd1 << (FRAC - 1));
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	// stage 1: operand selection
	logic signed [U-1:0] a_x, b_x, da, db;
	logic                v_s1, inv_s1, und_s1;
	logic signed [U-1:0] u0_s1, u1_s1;

	assign a_x = U'(in_first);
	assign b_x = U'(in_second);
	assign da  = a_x - U'(row_off);
	assign db  = b_x - U'(col_off);

	// stage 2: partial products
	logic signed [C-1:0]  kx [4];
	logic signed [U-1:0]  ux [4];
	logic signed [C+LO:0] pl_s2 [4];
	logic signed [C+HI-1:0] ph_s2 [4];
	logic signed [RW-1:0] dpa_s2, dpb_s2;
	logic                 v_s2, inv_s2, und_s2;

	// stage 3: full products
	logic signed [PW-1:0] p_s3 [4];
	logic signed [DW-1:0] det_s3;
	logic                 v_s3, inv_s3, und_s3;

	// stage 4: sums
	logic signed [SW-1:0] sum0_s4, sum1_s4;
	logic signed [DW-1:0] det_s4;
	logic                 v_s4, inv_s4, und_s4;

	// stage 5: rounding and magnitudes
	logic [SW-1:0]        an0_c, an1_c;
	logic [DW-1:0]        adw_c;
	logic signed [SW-1:0] fr0_s5, fr1_s5;
	logic [SW-1:0]        an0_s5, an1_s5;
	logic [RW-1:0]        ad_s5;
	logic                 v_s5, inv_s5, und_s5, neg0_s5, neg1_s5, sing_s5;

	// stage 6: offset, clamp and divider set-up
	logic signed [SW-1:0] c0, c1;
	logic                 ov_c0, ov_c1, ovf0, ovf1;
	logic [W-1:0]         f0_c, f1_c;

	assign kx[0] = inv_s1 ? m22 : m11;
	assign kx[1] = m12;
	assign kx[2] = m21;
	assign kx[3] = inv_s1 ? m11 : m22;
	assign ux[0] = u0_s1;
	assign ux[1] = u1_s1;
	assign ux[2] = u0_s1;
	assign ux[3] = u1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			ctl_o <= '0;
		end else if (en) begin
			v_s1      <= in_vld;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			ctl_o.vld <= v_s5;
			ctl_o.inv <= inv_s5;
			ctl_o.undef <= und_s5;
			ctl_o.sing  <= sing_s5;
			ctl_o.fsat  <= ov_c0 | ov_c1;
			ctl_o.ovf0  <= ovf0;
			ctl_o.neg0  <= neg0_s5;
			ctl_o.ovf1  <= ovf1;
			ctl_o.neg1  <= neg1_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inv_s1 <= in_inv;
			und_s1 <= in_undef;
			u0_s1  <= in_inv ? db : a_x;
			u1_s1  <= in_inv ? da : b_x;
		end
	end

	generate
		for (genvar j = 0; j < 4; j++) begin : g_mul
			always_ff @(posedge clk) begin
				if (en) begin
					pl_s2[j] <= kx[j] * $signed({1'b0, ux[j][LO-1:0]});
					ph_s2[j] <= kx[j] * $signed(ux[j][U-1:LO]);
					p_s3[j]  <= (PW'(ph_s2[j]) <<< LO) + PW'(pl_s2[j]);
				end
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			dpa_s2 <= m11 * m22;
			dpb_s2 <= m12 * m21;
			inv_s2 <= inv_s1;
			und_s2 <= und_s1;

			det_s3 <= DW'(dpa_s2) - DW'(dpb_s2);
			inv_s3 <= inv_s2;
			und_s3 <= und_s2;

			sum0_s4 <= inv_s3 ? SW'(p_s3[0]) - SW'(p_s3[1]) : SW'(p_s3[0]) + SW'(p_s3[1]);
			sum1_s4 <= inv_s3 ? SW'(p_s3[3]) - SW'(p_s3[2]) : SW'(p_s3[3]) + SW'(p_s3[2]);
			det_s4  <= det_s3;
			inv_s4  <= inv_s3;
			und_s4  <= und_s3;

			fr0_s5  <= (sum0_s4 + RND) >>> FRAC;
			fr1_s5  <= (sum1_s4 + RND) >>> FRAC;
			an0_s5  <= an0_c;
			an1_s5  <= an1_c;
			ad_s5   <= adw_c[RW-1:0];
			neg0_s5 <= sum0_s4[SW-1] ^ det_s4[DW-1];
			neg1_s5 <= sum1_s4[SW-1] ^ det_s4[DW-1];
			sing_s5 <= (det_s4 == '0);
			inv_s5  <= inv_s4;
			und_s5  <= und_s4;

			d_o  <= ad_s5;
			r0_o <= ovf0 ? '0 : RW'(an0_s5 >> SH);
			r1_o <= ovf1 ? '0 : RW'(an1_s5 >> SH);
			q0_o <= {an0_s5[SH-1:0], {FRAC{1'b0}}};
			q1_o <= {an1_s5[SH-1:0], {FRAC{1'b0}}};
			f0_o <= f0_c;
			f1_o <= f1_c;
		end
	end

	assign an0_c = sum0_s4[SW-1] ? SW'(-sum0_s4) : SW'(sum0_s4);
	assign an1_c = sum1_s4[SW-1] ? SW'(-sum1_s4) : SW'(sum1_s4);
	assign adw_c = det_s4[DW-1] ? DW'(-det_s4) : DW'(det_s4);

	assign c0    = fr0_s5 + SW'(col_off);
	assign c1    = fr1_s5 + SW'(row_off);
	assign ov_c0 = (c0[SW-1:W-1] != {(SW-W+1){c0[SW-1]}});
	assign ov_c1 = (c1[SW-1:W-1] != {(SW-W+1){c1[SW-1]}});
	assign f0_c  = ov_c0 ? (c0[SW-1] ? MINV : MAXV) : c0[W-1:0];
	assign f1_c  = ov_c1 ? (c1[SW-1] ? MINV : MAXV) : c1[W-1:0];

	// quotient would not fit the divider's bit count
	assign ovf0 = XW'(an0_s5) >= (XW'(ad_s5) << SH);
	assign ovf1 = XW'(an1_s5) >= (XW'(ad_s5) << SH);

endmodule

// ===== rtl/core/agt_div_cell.sv =====
// one restoring divider cell: one quotient bit per lane, two lanes
module agt_div_cell #(
	parameter int COORD_WIDTH = 48,
	parameter int COEFF_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  agt_pkg::agt_ctl_t            ctl_i,
	input  logic [2*COEFF_WIDTH-1:0]     d_i,
	input  logic [2*COEFF_WIDTH-1:0]     r0_i,
	input  logic [COORD_WIDTH:0]         q0_i,
	input  logic [2*COEFF_WIDTH-1:0]     r1_i,
	input  logic [COORD_WIDTH:0]         q1_i,
	input  logic [COORD_WIDTH-1:0]       f0_i,
	input  logic [COORD_WIDTH-1:0]       f1_i,
	output agt_pkg::agt_ctl_t            ctl_o,
	output logic [2*COEFF_WIDTH-1:0]     d_o,
	output logic [2*COEFF_WIDTH-1:0]     r0_o,
	output logic [COORD_WIDTH:0]         q0_o,
	output logic [2*COEFF_WIDTH-1:0]     r1_o,
	output logic [COORD_WIDTH:0]         q1_o,
	output logic [COORD_WIDTH-1:0]       f0_o,
	output logic [COORD_WIDTH-1:0]       f1_o
);

	localparam int RW = 2 * COEFF_WIDTH;
	localparam int QB = COORD_WIDTH + 1;

	logic [RW:0] t0, t1;
	logic        ge0, ge1;

	assign t0  = {r0_i, q0_i[QB-1]};
	assign t1  = {r1_i, q1_i[QB-1]};
	assign ge0 = t0 >= {1'b0, d_i};
	assign ge1 = t1 >= {1'b0, d_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else if (en) begin
			ctl_o <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o  <= d_i;
			r0_o <= ge0 ? RW'(t0 - {1'b0, d_i}) : t0[RW-1:0];
			r1_o <= ge1 ? RW'(t1 - {1'b0, d_i}) : t1[RW-1:0];
			q0_o <= {q0_i[QB-2:0], ge0};
			q1_o <= {q1_i[QB-2:0], ge1};
			f0_o <= f0_i;
			f1_o <= f1_i;
		end
	end

endmodule

// ===== rtl/core/agt_back.sv =====
// quotient rounding, clamp, status and output register with skid stage
module agt_back #(
	parameter int COORD_WIDTH = 48,
	parameter int COEFF_WIDTH = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	output logic                                  en,
	input  agt_pkg::agt_ctl_t                     ctl_i,
	input  logic [2*COEFF_WIDTH-1:0]              d_i,
	input  logic [2*COEFF_WIDTH-1:0]              r0_i,
	input  logic [COORD_WIDTH:0]                  q0_i,
	input  logic [2*COEFF_WIDTH-1:0]              r1_i,
	input  logic [COORD_WIDTH:0]                  q1_i,
	input  logic [COORD_WIDTH-1:0]                f0_i,
	input  logic [COORD_WIDTH-1:0]                f1_i,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((2*COORD_WIDTH+7)/8)*8-1:0]    m_tdata,
	output logic [1:0]                            m_tuser
);

	localparam int W  = COORD_WIDTH;
	localparam int QB = W + 1;
	localparam int TW = ((2 * W + 7) / 8) * 8;
	localparam logic [QB:0] LIM = (QB + 1)'(1) << (W - 1);
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	agt_pkg::agt_ctl_t     ctl_b1;
	logic [QB:0]           qr0_b1, qr1_b1, nq0, nq1;
	logic [W-1:0]          f0_b1, f1_b1;
	logic                  inc0, inc1, sat0, sat1;
	logic [W-1:0]          v0, v1, pd0, pd1;
	agt_pkg::agt_status_t  pst;
	logic                  ov_q, sk_q;
	logic [W-1:0]          od0_q, od1_q, sd0_q, sd1_q;
	agt_pkg::agt_status_t  ost_q, sst_q;

	assign en   = ~sk_q;
	assign inc0 = {r0_i, 1'b0} >= {1'b0, d_i};
	assign inc1 = {r1_i, 1'b0} >= {1'b0, d_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_b1 <= '0;
		end else if (en) begin
			ctl_b1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qr0_b1 <= (QB + 1)'(q0_i) + (QB + 1)'(inc0);
			qr1_b1 <= (QB + 1)'(q1_i) + (QB + 1)'(inc1);
			f0_b1  <= f0_i;
			f1_b1  <= f1_i;
		end
	end

	assign nq0  = '0 - qr0_b1;
	assign nq1  = '0 - qr1_b1;
	assign sat0 = ctl_b1.ovf0 | (ctl_b1.neg0 ? (qr0_b1 > LIM) : (qr0_b1 >= LIM));
	assign sat1 = ctl_b1.ovf1 | (ctl_b1.neg1 ? (qr1_b1 > LIM) : (qr1_b1 >= LIM));
	assign v0   = sat0 ? (ctl_b1.neg0 ? MINV : MAXV)
			: (ctl_b1.neg0 ? nq0[W-1:0] : qr0_b1[W-1:0]);
	assign v1   = sat1 ? (ctl_b1.neg1 ? MINV : MAXV)
			: (ctl_b1.neg1 ? nq1[W-1:0] : qr1_b1[W-1:0]);

	always_comb begin
		pd0 = '0;
		pd1 = '0;
		pst = agt_pkg::ST_OK;
		if (ctl_b1.undef) begin
			pst = agt_pkg::ST_UNDEF;
		end else if (!ctl_b1.inv) begin
			pd0 = f0_b1;
			pd1 = f1_b1;
			pst = ctl_b1.fsat ? agt_pkg::ST_SAT : agt_pkg::ST_OK;
		end else if (ctl_b1.sing) begin
			pst = agt_pkg::ST_SINGULAR;
		end else begin
			pd0 = v0;
			pd1 = v1;
			pst = (sat0 | sat1) ? agt_pkg::ST_SAT : agt_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sk_q <= 1'b0;
		end else if (!ov_q || m_tready) begin
			if (sk_q) begin
				ov_q <= 1'b1;
				sk_q <= 1'b0;
			end else begin
				ov_q <= ctl_b1.vld;
			end
		end else if (ctl_b1.vld && !sk_q) begin
			sk_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ov_q || m_tready) begin
			if (sk_q) begin
				od0_q <= sd0_q;
				od1_q <= sd1_q;
				ost_q <= sst_q;
			end else begin
				od0_q <= pd0;
				od1_q <= pd1;
				ost_q <= pst;
			end
		end else if (!sk_q) begin
			sd0_q <= pd0;
			sd1_q <= pd1;
			sst_q <= pst;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = TW'({od1_q, od0_q});
	assign m_tuser  = ost_q;

endmodule

// ===== rtl/core/agt_checker.sv =====
// port-level checks of the affine georeference transform and their binding
module agt_checker #(
	parameter int COORD_WIDTH = 48,
	parameter int COEFF_WIDTH = 32
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  s_tready,
	input logic                                  m_tvalid,
	input logic                                  m_tready,
	input logic [((2*COORD_WIDTH+7)/8)*8-1:0]    m_tdata,
	input logic [1:0]                            m_tuser
);

	localparam int SLOTS = COEFF_WIDTH / COEFF_WIDTH;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	// undefined input gives zero results
	a_undef: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == agt_pkg::ST_UNDEF) |-> (m_tdata == '0))
		else $error("undefined input with nonzero result");

	// singular matrix gives zero results
	a_sing: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == agt_pkg::ST_SINGULAR) |-> (m_tdata == '0))
		else $error("singular matrix with nonzero result");

	// input side stalls only behind a stalled output
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready && (SLOTS == 1)))
		else $error("input stalled without output stall");

	// skid drains only on an output transaction
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> $past(m_tready))
		else $error("skid drained without output transaction");

endmodule

bind affine_georef_transform agt_checker #(
	.COORD_WIDTH(COORD_WIDTH),
	.COEFF_WIDTH(COEFF_WIDTH)
) u_agt_checker (.*);

// ===== sim/affine_georef_transform_tb.sv =====
// self-checking testbench for the affine georeference transform
`timescale 1ns / 1ps

module affine_georef_transform_tb;

	localparam int CW = 48;
	localparam int KW = 32;
	localparam int DW = ((2*CW+7)/8)*8;
	localparam int LATENCY = CW + 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic signed [159:0] COORD_MAX = (160'sd1 <<< (CW-1)) - 1;
	localparam logic signed [159:0] COORD_MIN = -(160'sd1 <<< (CW-1));
	localparam logic [159:0] MAG_MAX = (160'd1 << (CW-1)) - 1;
	localparam logic [159:0] MAG_MIN = 160'd1 << (CW-1);
	localparam logic signed [47:0] C_MAX = 48'sh7fff_ffff_ffff;
	localparam logic signed [47:0] C_MIN = 48'sh8000_0000_0000;
	localparam logic signed [31:0] K_ONE = 32'sd16777216;
	localparam logic signed [31:0] K_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] K_MIN = 32'sh8000_0000;
	localparam logic REQ_FWD = 1'b0;
	localparam logic REQ_INV = 1'b1;

	typedef struct {
		logic [CW-1:0] first;
		logic [CW-1:0] second;
		agt_pkg::agt_status_t status;
	} raster_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [agt_pkg::APB_AW-1:0] paddr = '0;
	logic [agt_pkg::APB_DW-1:0] pwdata = '0;
	logic [agt_pkg::APB_DW-1:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// first_in, second_in
	logic [DW-1:0] s_tdata = '0;
	// req_type, in_undefined
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// first_out, second_out
	logic [DW-1:0] m_tdata;
	// status
	logic [1:0] m_tuser;

	logic signed [KW-1:0] mat [4];
	logic signed [CW-1:0] off_col, off_row;
	raster_result_t pending_results[$];
	int mismatches = 0;
	int cycles = 0;
	int burst_left = 0;
	int rx_mode = 0;
	int hold_req = 0;
	int hold_left = 0;

	affine_georef_transform i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [CW-1:0] clamp_coord(input logic signed [159:0] v, inout bit flag);
		if (v > COORD_MAX) begin
			flag = 1'b1;
			return C_MAX;
		end
		if (v < COORD_MIN) begin
			flag = 1'b1;
			return C_MIN;
		end
		return v[CW-1:0];
	endfunction

	// nearest quotient in Q.24, ties away from zero
	function automatic logic [CW-1:0] divide_round(input logic signed [159:0] num,
			input logic signed [159:0] den, inout bit flag);
		logic [159:0] an, ad, q, r;
		logic [159:0] nq;
		bit negative;
		negative = num[159] ^ den[159];
		an = num[159] ? -num : num;
		ad = den[159] ? -den : den;
		q = (an << 24) / ad;
		r = (an << 24) % ad;
		if ((r << 1) >= ad)
			q = q + 1;
		if (!negative) begin
			if (q > MAG_MAX) begin
				flag = 1'b1;
				return C_MAX;
			end
			return q[CW-1:0];
		end
		if (q > MAG_MIN) begin
			flag = 1'b1;
			return C_MIN;
		end
		nq = -q;
		return nq[CW-1:0];
	endfunction

	function automatic raster_result_t georef_predict(input logic [1:0] user,
			input logic [DW-1:0] data);
		raster_result_t res;
		logic signed [CW-1:0] a, b;
		logic signed [159:0] pc, pr, det, da, db, nx, ny;
		bit flag;
		a = data[CW-1:0];
		b = data[2*CW-1:CW];
		flag = 1'b0;
		res.first = '0;
		res.second = '0;
		if (user[1]) begin
			res.status = agt_pkg::ST_UNDEF;
			return res;
		end
		if (user[0] == REQ_FWD) begin
			pc = mat[agt_pkg::REG_M11] * a + mat[agt_pkg::REG_M12] * b;
			pr = mat[agt_pkg::REG_M21] * a + mat[agt_pkg::REG_M22] * b;
			pc = ((pc + (160'sd1 <<< 23)) >>> 24) + off_col;
			pr = ((pr + (160'sd1 <<< 23)) >>> 24) + off_row;
			res.first = clamp_coord(pc, flag);
			res.second = clamp_coord(pr, flag);
		end else begin
			det = mat[agt_pkg::REG_M11] * mat[agt_pkg::REG_M22]
				- mat[agt_pkg::REG_M12] * mat[agt_pkg::REG_M21];
			if (det == 0) begin
				res.status = agt_pkg::ST_SINGULAR;
				return res;
			end
			db = b - off_col;
			da = a - off_row;
			nx = mat[agt_pkg::REG_M22] * db - mat[agt_pkg::REG_M12] * da;
			ny = mat[agt_pkg::REG_M11] * da - mat[agt_pkg::REG_M21] * db;
			res.first = divide_round(nx, det, flag);
			res.second = divide_round(ny, det, flag);
		end
		res.status = flag ? agt_pkg::ST_SAT : agt_pkg::ST_OK;
		return res;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("affine_georef_transform_tb: errors");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && s_tvalid && s_tready)
			pending_results.push_back(georef_predict(s_tuser, s_tdata));

	always @(posedge clk) begin
		raster_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h status %0d", m_tdata, m_tuser);
			end else begin
				exp_r = pending_results.pop_front();
				if (m_tdata[CW-1:0] !== exp_r.first || m_tdata[2*CW-1:CW] !== exp_r.second ||
						m_tuser !== exp_r.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h %h st %0d, got %h %h st %0d",
							exp_r.first, exp_r.second, exp_r.status,
							m_tdata[CW-1:0], m_tdata[2*CW-1:CW], m_tuser);
				end
			end
		end
	end

	// receiver stall pattern, with an optional long hold-off
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_mode == 0)
			m_tready <= 1'b1;
		else if (rx_mode == 1)
			m_tready <= ($urandom_range(0, 9) < 7);
		else
			m_tready <= (cycles % 7) != 3 && (cycles % 11) != 5;
	end

	task automatic reg_write(input agt_pkg::agt_reg_t idx, input logic signed [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= agt_pkg::APB_AW'(idx * 8);
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			agt_pkg::REG_COL_OFF: off_col = value[CW-1:0];
			agt_pkg::REG_ROW_OFF: off_row = value[CW-1:0];
			default: mat[idx] = value[KW-1:0];
		endcase
	endtask

	task automatic set_config(input logic signed [31:0] k11, k12, k21, k22,
			input logic signed [47:0] oc, orow);
		reg_write(agt_pkg::REG_M11, k11);
		reg_write(agt_pkg::REG_M12, k12);
		reg_write(agt_pkg::REG_M21, k21);
		reg_write(agt_pkg::REG_M22, k22);
		reg_write(agt_pkg::REG_COL_OFF, oc);
		reg_write(agt_pkg::REG_ROW_OFF, orow);
	endtask

	// sender works in bursts with random gaps
	task automatic send_request(input logic req, input logic signed [47:0] a,
			input logic signed [47:0] b, input logic undef);
		s_tvalid <= 1'b1;
		s_tdata <= {{(DW-2*CW){1'b0}}, b, a};
		s_tuser <= {undef, req};
		do @(posedge clk); while (!s_tready);
		if (burst_left > 0)
			burst_left--;
		else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 20);
		end
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	function automatic logic signed [47:0] rand_coord;
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: return r[47:0];
			1: return $urandom_range(0, 1) ? C_MAX - r[3:0] : C_MIN + r[3:0];
			2: return {{20{r[27]}}, r[27:0]};
			default: return {{12{r[35]}}, r[35:0]};
		endcase
	endfunction

	function automatic logic signed [31:0] rand_coeff;
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 6))
			0: return r;
			1: return 32'sd0;
			2: return $urandom_range(0, 1) ? K_ONE : -K_ONE;
			3: return $urandom_range(0, 1) ? K_MAX : K_MIN;
			default: return {{6{r[25]}}, r[25:0]};
		endcase
	endfunction

	task automatic send_random(input int count);
		repeat (count)
			send_request(1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
				$urandom_range(0, 15) == 0);
	endtask

	task automatic test_reset_config;
		send_request(REQ_FWD, 48'sd0, 48'sd0, 1'b0);
		send_request(REQ_FWD, C_MAX, C_MAX, 1'b0);
		send_request(REQ_FWD, C_MIN, C_MIN, 1'b0);
		send_request(REQ_FWD, 48'sh0000_0001_8000, -48'sd98304, 1'b0);
		send_request(REQ_INV, C_MAX, C_MIN, 1'b0);
		send_request(REQ_INV, C_MIN, C_MAX, 1'b0);
		send_request(REQ_INV, 48'sd65536, -48'sd1, 1'b0);
		send_request(REQ_FWD, C_MAX, C_MIN, 1'b1);
		send_request(REQ_INV, -48'sd1, 48'sd1, 1'b1);
		drain();
	endtask

	task automatic test_extremes;
		set_config(K_MAX, K_MAX, K_MIN, K_MIN, C_MAX, C_MIN);
		send_request(REQ_FWD, C_MAX, C_MAX, 1'b0);
		send_request(REQ_FWD, C_MIN, C_MAX, 1'b0);
		send_request(REQ_INV, C_MAX, C_MIN, 1'b0);
		send_request(REQ_FWD, 48'sd0, 48'sd0, 1'b0);
		drain();
		set_config(32'sd0, 32'sd0, 32'sd0, 32'sd0, C_MIN, C_MAX);
		send_request(REQ_INV, 48'sd5, 48'sd7, 1'b0);
		send_request(REQ_FWD, 48'sd5, 48'sd7, 1'b0);
		send_request(REQ_INV, 48'sd5, 48'sd7, 1'b1);
		drain();
		// tiny determinants scale the inverse up, then a scaled diagonal matrix with offsets
		set_config(32'sd1, 32'sd0, 32'sd0, 32'sd1, 48'sd0, 48'sd0);
		send_request(REQ_INV, 48'sd1, -48'sd1, 1'b0);
		drain();
		set_config(32'sd2, 32'sd0, 32'sd0, 32'sd2, 48'sd0, 48'sd0);
		send_request(REQ_INV, -48'sd1, 48'sd1, 1'b0);
		drain();
		set_config(32'sd50331648, 32'sd0, 32'sd0, 32'sd33554432, 48'sd1, -48'sd1);
		send_request(REQ_INV, 48'sd1, 48'sd2, 1'b0);
		send_request(REQ_INV, -48'sd3, -48'sd1, 1'b0);
		send_request(REQ_FWD, 48'sd1, -48'sd1, 1'b0);
		drain();
	endtask

	task automatic test_random_phases;
		for (int ph = 0; ph < 5; ph++) begin
			rx_mode = ph % 3;
			set_config(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(),
				rand_coord(), rand_coord());
			send_random(140);
			drain();
		end
	endtask

	task automatic test_backpressure;
		rx_mode = 1;
		set_config(K_ONE, 32'sd8388608, -32'sd4194304, -K_ONE, 48'sd1000, -48'sd2000);
		hold_req = 300;
		burst_left = 1000;
		send_random(150);
		burst_left = 0;
		drain();
	endtask

	initial begin
		mat[agt_pkg::REG_M11] = K_ONE;
		mat[agt_pkg::REG_M12] = 32'sd0;
		mat[agt_pkg::REG_M21] = 32'sd0;
		mat[agt_pkg::REG_M22] = -K_ONE;
		off_col = '0;
		off_row = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_config();
		test_extremes();
		test_random_phases();
		test_backpressure();
		if (mismatches == 0 && pending_results.size() == 0)
			$display("affine_georef_transform_tb: clean");
		else
			$display("affine_georef_transform_tb: errors");
		$finish;
	end

endmodule

// ===== affine_georef_transform.f =====
rtl/core/agt_pkg.sv
rtl/core/agt_cfg.sv
rtl/core/agt_front.sv
rtl/core/agt_div_cell.sv
rtl/core/agt_back.sv
rtl/core/affine_georef_transform.sv
rtl/core/agt_checker.sv
sim/affine_georef_transform_tb.sv
